>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the multiset table.
// Each macro expects the including module to have i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DHMT_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DHMT_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/dhmt_pkg.sv
// Shared types and constants of the double-hashed multiset table.
// No dependencies; imported by dhmt_hash and the top-level core.
`timescale 1ns / 1ps
`default_nettype none

package dhmt_pkg;

    // Default sizing of the table and of the stored key.
    localparam int DEF_CAPACITY  = 1024;
    localparam int DEF_KEY_WIDTH = 32;

    // Fixed field widths of the streaming and register interfaces.
    localparam int ELEM_W   = 32;
    localparam int KIND_W   = 2;
    localparam int CNT_W    = 11;
    localparam int CFG_W    = 4;
    localparam int RES_W    = 24;
    localparam int APB_W    = 32;
    localparam int PADDR_W  = 3;

    localparam logic [CFG_W-1:0] CFG_SLOTS_RESET = 4'd10;
    localparam logic [CNT_W-1:0] COUNT_SAT       = 11'd2047;

    // Register index of slots_log2 (taken from paddr[2]).
    localparam logic REG_SLOTS_LOG2 = 1'b0;

    // Per-slot status codes.
    localparam logic [1:0] ST_EMPTY   = 2'd0;
    localparam logic [1:0] ST_LIVE    = 2'd1;
    localparam logic [1:0] ST_DELETED = 2'd2;

    // Request kinds carried in tuser.
    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_SEARCH = 2'd2,
        KIND_COUNT  = 2'd3
    } t_kind;

endpackage

`default_nettype wire

>>> rtl/dhmt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; instanced for the status and the key stores.
`timescale 1ns / 1ps
`default_nettype none

module dhmt_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/dhmt_hash.sv
// Key extraction and double-hash setup: start slot, odd step and size mask.
// Depends on dhmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dhmt_hash
    import dhmt_pkg::*;
#(
    parameter int KEY_WIDTH = DEF_KEY_WIDTH,
    parameter int ADDR_W    = 10
) (
    input  wire [ELEM_W-1:0]    i_elem,
    input  wire [CFG_W-1:0]     i_slots_log2,
    output logic [KEY_WIDTH-1:0] o_key,
    output logic [ADDR_W-1:0]   o_pos,
    output logic [ADDR_W-1:0]   o_step,
    output logic [ADDR_W-1:0]   o_mask
);

    localparam int MW = (KEY_WIDTH > ADDR_W) ? KEY_WIDTH : ADDR_W;
    localparam logic [ADDR_W-1:0] ALL_ONES = '1;

    logic signed [ELEM_W-1:0]    elem_s;
    logic [KEY_WIDTH-1:0]        mag_k;
    logic [MW-1:0]               mag_ext;
    logic [ADDR_W-1:0]           mag_lo;
    logic [4:0]                  eff_log2;

    // The key is the elem sign-extended or cut to the key width.
    assign elem_s = $signed(i_elem);
    assign o_key  = KEY_WIDTH'(elem_s);

    // Magnitude; the most negative key maps to 2^(KEY_WIDTH-1) without overflow.
    assign mag_k   = o_key[KEY_WIDTH-1] ? (~o_key + 1'b1) : o_key;
    assign mag_ext = MW'(mag_k);
    assign mag_lo  = mag_ext[ADDR_W-1:0];

    // Active size: at least two slots, at most the memory depth.
    always_comb begin
        eff_log2 = (i_slots_log2 == '0) ? 5'd1 : 5'(i_slots_log2);
        if (eff_log2 > 5'(ADDR_W)) begin
            eff_log2 = 5'(ADDR_W);
        end
    end

    assign o_mask = ALL_ONES >> (5'(ADDR_W) - eff_log2);
    assign o_pos  = mag_lo & o_mask;

    // Step is one plus the rounded-up-to-even magnitude mod m, so it is odd.
    assign o_step = mag_lo[0] ? (((mag_lo + 1'b1) & o_mask) + 1'b1)
                              : ((mag_lo & o_mask) + 1'b1);

endmodule

`default_nettype wire

>>> rtl/double_hash_multiset_table_core.sv
// Top level of the double-hashed multiset table: APB register, stream ports,
// probe sequencer and the two slot memories. Depends on dhmt_pkg, dhmt_hash,
// dhmt_ram and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// Open-addressed multiset of signed keys with double hashing. Each request
// (add, remove, search, count) enters on the slave stream and gives exactly one
// result on the master stream. The slot status and the slot keys live in two
// RAMs with a registered read; the sequencer issues one probe read per cycle
// and checks one returned slot per cycle. A request checks 1 to m slots, where
// m is the active slot count; a search on an empty table checks none. After
// reset a clearing pass marks every slot empty, and no request is taken
// while it runs; the register port works as usual during it. A finished
// result waits in an output register while the next request is taken.
// slots_log2 must only be written while no request is in flight.
module double_hash_multiset_table_core
    import dhmt_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // Request stream.
    input  wire                  i_s_tvalid,
    output logic                 o_s_tready,
    input  wire [ELEM_W-1:0]     i_s_tdata,   // [31:0] elem
    input  wire [KIND_W-1:0]     i_s_tuser,   // [1:0] kind
    // Result stream.
    output logic                 o_m_tvalid,
    input  wire                  i_m_tready,
    output logic [RES_W-1:0]     o_m_tdata,   // [0] done_ok, [1] table_full,
                                              // [12:2] occurrences, [23:13] stored_total
    // Register port.
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire [PADDR_W-1:0]    paddr,
    input  wire [APB_W-1:0]      pwdata,
    output logic [APB_W-1:0]     prdata,
    output logic                 pready
);

    localparam int AW     = $clog2(CAPACITY + 1) - 1;
    localparam int SLOTS  = 1 << AW;
    localparam int LIVE_W = $clog2(CAPACITY + 1);
    localparam logic [LIVE_W-1:0] LIVE_MAX  = LIVE_W'(SLOTS);
    localparam logic [AW-1:0]     ADDR_LAST = '1;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_PROBE  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    function automatic logic [CNT_W-1:0] sat_cnt(input logic [31:0] v);
        sat_cnt = (v > 32'(COUNT_SAT)) ? COUNT_SAT : v[CNT_W-1:0];
    endfunction

    // Control registers.
    t_state               r_state, n_state;
    logic [AW-1:0]        r_clr_addr, n_clr_addr;
    logic [CFG_W-1:0]     r_slots_log2;
    logic [LIVE_W-1:0]    r_live, n_live;
    logic                 r_iss_done, n_iss_done;
    logic                 r_rd_vld, n_rd_vld;
    logic                 r_o_valid, n_o_valid;

    // Payload registers.
    t_kind                r_kind, n_kind;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic [AW-1:0]        r_mask, n_mask;
    logic [AW-1:0]        r_step, n_step;
    logic [AW-1:0]        r_pos, n_pos;
    logic [AW-1:0]        r_iss, n_iss;
    logic [AW-1:0]        r_rd_addr, n_rd_addr;
    logic [AW-1:0]        r_chk, n_chk;
    logic [AW:0]          r_occ, n_occ;
    logic                 r_ok, n_ok;
    logic                 r_full, n_full;
    logic [RES_W-1:0]     r_o_tdata, n_o_tdata;

    // Hash setup outputs.
    logic [KEY_WIDTH-1:0] h_key;
    logic [AW-1:0]        h_pos;
    logic [AW-1:0]        h_step;
    logic [AW-1:0]        h_mask;

    // Memory ports.
    logic                 st_we;
    logic [AW-1:0]        st_waddr;
    logic [1:0]           st_wdata;
    logic [1:0]           st_rdata;
    logic                 key_we;
    logic [KEY_WIDTH-1:0] key_rdata;

    logic                 accept;
    logic                 issue;
    logic                 eval;
    logic                 last;
    logic                 key_hit;
    logic                 out_load;
    logic                 cfg_wr;

    // Register port: always ready, one register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_SLOTS_LOG2) ? APB_W'(r_slots_log2) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_log2 <= CFG_SLOTS_RESET;
        end else if (cfg_wr && (paddr[2] == REG_SLOTS_LOG2)) begin
            r_slots_log2 <= pwdata[CFG_W-1:0];
        end
    end

    dhmt_hash #(
        .KEY_WIDTH (KEY_WIDTH),
        .ADDR_W    (AW)
    ) u_hash (
        .i_elem       (i_s_tdata),
        .i_slots_log2 (r_slots_log2),
        .o_key        (h_key),
        .o_pos        (h_pos),
        .o_step       (h_step),
        .o_mask       (h_mask)
    );

    // Handshake and probe strobes.
    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign issue      = (r_state == S_PROBE) && !r_iss_done;
    assign eval       = (r_state == S_PROBE) && r_rd_vld;
    assign last       = (r_chk == r_mask);
    assign key_hit    = (st_rdata == ST_LIVE) && (key_rdata == r_key);
    assign out_load   = (r_state == S_FINISH) && (!r_o_valid || i_m_tready);

    // Memory writes: the clearing pass, or the single write that ends an add
    // or a remove.
    always_comb begin
        st_we    = 1'b0;
        st_waddr = r_rd_addr;
        st_wdata = ST_LIVE;
        key_we   = 1'b0;
        if (r_state == S_CLEAR) begin
            st_we    = 1'b1;
            st_waddr = r_clr_addr;
            st_wdata = ST_EMPTY;
        end else if (eval) begin
            if (r_kind == KIND_ADD && st_rdata != ST_LIVE) begin
                st_we  = 1'b1;
                key_we = 1'b1;
            end else if (r_kind == KIND_REMOVE && key_hit) begin
                st_we    = 1'b1;
                st_wdata = ST_DELETED;
            end
        end
    end

    dhmt_ram #(
        .WIDTH (2),
        .DEPTH (SLOTS)
    ) u_status_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (issue),
        .i_raddr (r_pos),
        .o_rdata (st_rdata)
    );

    dhmt_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_rd_addr),
        .i_wdata (r_key),
        .i_re    (issue),
        .i_raddr (r_pos),
        .o_rdata (key_rdata)
    );

    // Sequencer: setup on transfer, one probe issued and one checked per cycle.
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_live     = r_live;
        n_iss_done = r_iss_done;
        n_rd_vld   = issue;
        n_o_valid  = r_o_valid;
        n_kind     = r_kind;
        n_key      = r_key;
        n_mask     = r_mask;
        n_step     = r_step;
        n_pos      = r_pos;
        n_iss      = r_iss;
        n_rd_addr  = r_pos;
        n_chk      = r_chk;
        n_occ      = r_occ;
        n_ok       = r_ok;
        n_full     = r_full;
        n_o_tdata  = r_o_tdata;

        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_kind     = t_kind'(i_s_tuser);
                    n_key      = h_key;
                    n_mask     = h_mask;
                    n_step     = h_step;
                    n_pos      = h_pos;
                    n_iss      = '0;
                    n_iss_done = 1'b0;
                    n_chk      = '0;
                    n_occ      = '0;
                    n_ok       = 1'b0;
                    n_full     = 1'b0;
                    if (t_kind'(i_s_tuser) == KIND_SEARCH && r_live == '0) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                // Issue side: the probe sequence does not depend on read data.
                if (issue) begin
                    n_pos = (r_pos + r_step) & r_mask;
                    n_iss = r_iss + 1'b1;
                    if (r_iss == r_mask) begin
                        n_iss_done = 1'b1;
                    end
                end
                // Check side: one returned slot per cycle.
                if (eval) begin
                    n_chk = r_chk + 1'b1;
                    case (r_kind)
                        KIND_ADD: begin
                            if (st_rdata != ST_LIVE) begin
                                n_live  = r_live + 1'b1;
                                n_ok    = 1'b1;
                                n_state = S_FINISH;
                            end else if (last) begin
                                n_full  = 1'b1;
                                n_state = S_FINISH;
                            end
                        end
                        KIND_REMOVE, KIND_SEARCH: begin
                            if (st_rdata == ST_EMPTY) begin
                                n_state = S_FINISH;
                            end else if (key_hit) begin
                                n_ok    = 1'b1;
                                n_state = S_FINISH;
                                if (r_kind == KIND_REMOVE) begin
                                    n_live = r_live - 1'b1;
                                end
                            end else if (last) begin
                                n_state = S_FINISH;
                            end
                        end
                        KIND_COUNT: begin
                            if (st_rdata == ST_EMPTY) begin
                                n_state = S_FINISH;
                            end else begin
                                n_occ = r_occ + (AW + 1)'(key_hit);
                                if (last) begin
                                    n_state = S_FINISH;
                                end
                            end
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end
            S_FINISH: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Output register: loaded when free or being drained.
        if (out_load) begin
            n_o_valid = 1'b1;
            n_o_tdata = {sat_cnt(32'(r_live)), sat_cnt(32'(r_occ)), r_full, r_ok};
        end else if (i_m_tready) begin
            n_o_valid = 1'b0;
        end
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_live     <= '0;
            r_iss_done <= 1'b1;
            r_rd_vld   <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_live     <= n_live;
            r_iss_done <= n_iss_done;
            r_rd_vld   <= n_rd_vld;
            r_o_valid  <= n_o_valid;
        end
    end

    // Payload state.
    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_key     <= n_key;
        r_mask    <= n_mask;
        r_step    <= n_step;
        r_pos     <= n_pos;
        r_iss     <= n_iss;
        r_rd_addr <= n_rd_addr;
        r_chk     <= n_chk;
        r_occ     <= n_occ;
        r_ok      <= n_ok;
        r_full    <= n_full;
        r_o_tdata <= n_o_tdata;
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_tdata;

`include "assert_macros.svh"

    // The live count never exceeds the number of physical slots.
    `DHMT_CHECK(a_live_bound, 1'b1, r_live <= LIVE_MAX, "live count above slot count")
    // Key writes only come from a checked probe of an add.
    `DHMT_CHECK(a_key_write_src, key_we, eval && r_kind == KIND_ADD, "stray key write")
    // No request is taken while the clearing pass runs.
    `DHMT_CHECK(a_no_take_in_clear, r_state == S_CLEAR, !o_s_tready, "request during clear")
    // A search on an empty table skips probing.
    `DHMT_CHECK_NEXT(a_empty_search, accept && t_kind'(i_s_tuser) == KIND_SEARCH
        && r_live == '0, r_state == S_FINISH, "empty search probed")

endmodule

`default_nettype wire
